@@ hdl/clcg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcg_pkg
// Shared types, constants and modular arithmetic of the combined generator.
// ----------------------------------------------------------------------------
package clcg_pkg;

	localparam int unsigned STATE_W = 31;
	localparam int unsigned MUL_W   = 16;
	localparam int unsigned RED_W   = 8;
	localparam int unsigned PROD_W  = STATE_W + MUL_W;

	localparam logic [STATE_W-1:0] MOD_ONE  = 31'd2147483563;
	localparam logic [STATE_W-1:0] MOD_TWO  = 31'd2147483399;
	localparam logic [MUL_W-1:0]   MUL_ONE  = 16'd40014;
	localparam logic [MUL_W-1:0]   MUL_TWO  = 16'd40692;
	localparam logic [STATE_W-1:0] SEED_ONE = 31'd2147483562;
	localparam logic [STATE_W-1:0] SEED_TWO = 31'd2147483398;

	// 2^31 mod m, used to fold the high part of a product back in
	localparam logic [RED_W-1:0] RED_ONE = RED_W'(32'h8000_0000 - 32'(MOD_ONE));
	localparam logic [RED_W-1:0] RED_TWO = RED_W'(32'h8000_0000 - 32'(MOD_TWO));

	typedef enum logic [1:0] {
		OP_SEED  = 2'd0,
		OP_NEXT  = 2'd1,
		OP_SPLIT = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [STATE_W-1:0] seed_a;
		logic [STATE_W-1:0] seed_b;
	} item_t;

	typedef struct packed {
		logic [STATE_W-1:0] random_value;
		logic [STATE_W-1:0] child_first;
		logic [STATE_W-1:0] child_second;
	} result_t;

	typedef struct packed {
		logic [STATE_W-1:0] first;
		logic [STATE_W-1:0] second;
	} gen_state_t;

	// x * mul mod m, with m = 2^31 - red
	function automatic logic [STATE_W-1:0] mulmod(
		input logic [STATE_W-1:0] x,
		input logic [MUL_W-1:0]   mul,
		input logic [RED_W-1:0]   red,
		input logic [STATE_W-1:0] m
	);
		logic [PROD_W-1:0]      prod;
		logic [MUL_W+RED_W-1:0] hi_red;
		logic [STATE_W:0]       sum;
		prod   = PROD_W'(x) * PROD_W'(mul);
		hi_red = (MUL_W+RED_W)'(prod[PROD_W-1:STATE_W]) * (MUL_W+RED_W)'(red);
		sum    = {1'b0, prod[STATE_W-1:0]} + (STATE_W+1)'(hi_red);
		if (sum >= {1'b0, m}) begin
			sum = sum - {1'b0, m};
		end
		return sum[STATE_W-1:0];
	endfunction

	// seed mod m plus one, seed below 2m
	function automatic logic [STATE_W-1:0] seed_load(
		input logic [STATE_W-1:0] seed,
		input logic [STATE_W-1:0] m
	);
		logic [STATE_W-1:0] r;
		r = (seed >= m) ? seed - m : seed;
		return r + STATE_W'(1);
	endfunction

endpackage

@@ hdl/clcg_cmd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcg_cmd_if
// Command channel: opcode and seeds with valid/ready handshake.
// ----------------------------------------------------------------------------
interface clcg_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   opcode;
	logic [clcg_pkg::STATE_W-1:0] seed_a;
	logic [clcg_pkg::STATE_W-1:0] seed_b;

	modport source(output valid, opcode, seed_a, seed_b, input ready);
	modport sink(input valid, opcode, seed_a, seed_b, output ready);
endinterface

@@ hdl/clcg_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcg_rsp_if
// Response channel: drawn value and child generator with valid/ready.
// ----------------------------------------------------------------------------
interface clcg_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [clcg_pkg::STATE_W-1:0] random_value;
	logic [clcg_pkg::STATE_W-1:0] child_first;
	logic [clcg_pkg::STATE_W-1:0] child_second;

	modport source(output valid, random_value, child_first, child_second, input ready);
	modport sink(input valid, random_value, child_first, child_second, output ready);
endinterface

@@ hdl/combined_lcg_random_generator.sv @@
`timescale 1ns / 1ps
// One command (seed, draw or split) is accepted every clock while the command
// side is not stalled. The command is registered first in the input register.
// When it moves on, the generator state and the response register are updated
// together and its single response beat is presented on the response channel.
// A response stall can hold the command in the input register. That update
// loop sets the clock rate: a 31x16 constant multiply, a fold of the high part
// and one compare-subtract per state. A full response register that is not
// taken stalls the command side only while the input register is also full.
// After reset the generator behaves as if seeded with zero.
// ----------------------------------------------------------------------------
// combined_lcg_random_generator
// Splittable combined multiplicative congruential random generator.
// ----------------------------------------------------------------------------
module combined_lcg_random_generator (
	input  logic           clk,
	input  logic           arst_n,
	clcg_cmd_if.sink       cmd,
	clcg_rsp_if.source     rsp
);

	logic                 valid_s1;
	clcg_pkg::item_t      item_s1;
	logic                 valid_s2;
	clcg_pkg::result_t    res_s2;
	clcg_pkg::gen_state_t gen_q;
	clcg_pkg::gen_state_t gen_nxt;
	clcg_pkg::result_t    res_nxt;
	logic                 adv_s2;
	logic                 move_s1;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign move_s1   = valid_s1 && adv_s2;
	assign cmd.ready = !valid_s1 || adv_s2;

	clcg_core u_core (
		.item (item_s1),
		.cur  (gen_q),
		.nxt  (gen_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			gen_q.first  <= clcg_pkg::STATE_W'(1);
			gen_q.second <= clcg_pkg::STATE_W'(1);
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (move_s1) begin
				gen_q <= gen_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.opcode <= cmd.opcode;
			item_s1.seed_a <= cmd.seed_a;
			item_s1.seed_b <= cmd.seed_b;
		end
		if (move_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.random_value = res_s2.random_value;
	assign rsp.child_first  = res_s2.child_first;
	assign rsp.child_second = res_s2.child_second;

	// state stays in its generator range
	assert property (@(posedge clk) disable iff (!arst_n)
		gen_q.first != '0 && gen_q.first <= clcg_pkg::SEED_ONE)
		else $error("first state out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		gen_q.second != '0 && gen_q.second <= clcg_pkg::SEED_TWO)
		else $error("second state out of range");

	// a command leaving the input register lands in the response register
	assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> valid_s2)
		else $error("beat lost between stages");

	// state only changes when a command is processed
	assert property (@(posedge clk) disable iff (!arst_n)
		!move_s1 |=> $stable(gen_q))
		else $error("state changed without a command");

	// a draw and a split never share a beat
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.random_value != '0 |-> res_s2.child_first == '0)
		else $error("draw and split fields both set");

endmodule

@@ hdl/clcg_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcg_core
// Next-state and result logic for one command against the generator state.
// ----------------------------------------------------------------------------
module clcg_core (
	input  clcg_pkg::item_t      item,
	input  clcg_pkg::gen_state_t cur,
	output clcg_pkg::gen_state_t nxt,
	output clcg_pkg::result_t    res
);

	logic [clcg_pkg::STATE_W-1:0] adv_first;
	logic [clcg_pkg::STATE_W-1:0] adv_second;
	logic [clcg_pkg::STATE_W:0]   diff;
	logic [clcg_pkg::STATE_W:0]   folded;
	logic [clcg_pkg::STATE_W-1:0] inc_first;
	logic [clcg_pkg::STATE_W-1:0] dec_second;

	always_comb begin
		adv_first  = clcg_pkg::mulmod(cur.first, clcg_pkg::MUL_ONE, clcg_pkg::RED_ONE,
			clcg_pkg::MOD_ONE);
		adv_second = clcg_pkg::mulmod(cur.second, clcg_pkg::MUL_TWO, clcg_pkg::RED_TWO,
			clcg_pkg::MOD_TWO);

		// two's complement difference, sign in the top bit
		diff = {1'b0, adv_first} - {1'b0, adv_second};
		if (diff[clcg_pkg::STATE_W] || diff == '0) begin
			folded = diff + {1'b0, clcg_pkg::SEED_ONE};
		end else if (diff >= {1'b0, clcg_pkg::SEED_ONE}) begin
			folded = diff - {1'b0, clcg_pkg::SEED_ONE};
		end else begin
			folded = diff;
		end

		inc_first  = (cur.first == clcg_pkg::SEED_ONE) ? clcg_pkg::STATE_W'(1)
			: cur.first + clcg_pkg::STATE_W'(1);
		dec_second = (cur.second == clcg_pkg::STATE_W'(1)) ? clcg_pkg::SEED_TWO
			: cur.second - clcg_pkg::STATE_W'(1);

		nxt = cur;
		res = '0;
		case (clcg_pkg::op_t'(item.opcode))
			clcg_pkg::OP_SEED: begin
				nxt.first  = clcg_pkg::seed_load(item.seed_a, clcg_pkg::SEED_ONE);
				nxt.second = clcg_pkg::seed_load(item.seed_b, clcg_pkg::SEED_TWO);
			end
			clcg_pkg::OP_NEXT: begin
				nxt.first        = adv_first;
				nxt.second       = adv_second;
				res.random_value = folded[clcg_pkg::STATE_W-1:0];
			end
			clcg_pkg::OP_SPLIT: begin
				nxt.first        = inc_first;
				nxt.second       = adv_second;
				res.child_first  = adv_first;
				res.child_second = dec_second;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

@@ dv/tb_combined_lcg_random_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_combined_lcg_random_generator
// Drives seed, draw, split and unused commands into the combined generator.
// A built-in predictor of both generator states works out each response
// beat, and every beat is compared field by field. Random traffic runs with
// no idling, with sender gaps, with receiver stalls and with both.
// ----------------------------------------------------------------------------
module tb_combined_lcg_random_generator;
	import clcg_pkg::*;

	typedef longint unsigned u64_t;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [STATE_W-1:0] SEED_MAX = 31'h7FFF_FFFF;

	logic clk;
	logic arst_n;

	clcg_cmd_if cmd ();
	clcg_rsp_if rsp ();

	combined_lcg_random_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.rsp    (rsp.source)
	);

	// predicted generator state
	logic [STATE_W-1:0] lcg_one;
	logic [STATE_W-1:0] lcg_two;

	result_t pending_responses[$];
	result_t want_rsp;
	int      idle_pct;
	int      stall_pct;
	int      error_count;
	int      checked_count;
	int      op_count[4];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [STATE_W-1:0] scaled_mod(
		input logic [STATE_W-1:0] x,
		input u64_t               mul,
		input u64_t               m
	);
		return STATE_W'((u64_t'(x) * mul) % m);
	endfunction

	function automatic logic [STATE_W-1:0] draw_value();
		logic [STATE_W-1:0] a;
		logic [STATE_W-1:0] b;
		longint             diff;
		a = scaled_mod(lcg_one, MUL_ONE, MOD_ONE);
		b = scaled_mod(lcg_two, MUL_TWO, MOD_TWO);
		lcg_one = a;
		lcg_two = b;
		diff = longint'(a) - longint'(b);
		if (diff < 1) begin
			diff = diff + longint'(SEED_ONE);
		end else begin
			diff = diff % longint'(SEED_ONE);
		end
		return STATE_W'(diff);
	endfunction

	function automatic result_t generator_response(input item_t it);
		result_t            r;
		logic [STATE_W-1:0] up_one;
		logic [STATE_W-1:0] down_two;
		r = '0;
		case (it.opcode)
			OP_SEED: begin
				lcg_one = STATE_W'(u64_t'(it.seed_a) % SEED_ONE + 1);
				lcg_two = STATE_W'(u64_t'(it.seed_b) % SEED_TWO + 1);
			end
			OP_NEXT: begin
				r.random_value = draw_value();
			end
			OP_SPLIT: begin
				up_one = (lcg_one == SEED_ONE) ? STATE_W'(1) : lcg_one + STATE_W'(1);
				down_two = (lcg_two == STATE_W'(1)) ? SEED_TWO : lcg_two - STATE_W'(1);
				void'(draw_value());
				r.child_first = lcg_one;
				r.child_second = down_two;
				lcg_one = up_one;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic send_cmd(
		input logic [1:0]         op,
		input logic [STATE_W-1:0] sa,
		input logic [STATE_W-1:0] sb
	);
		item_t it;
		while ($urandom_range(99) < idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		it.opcode = op;
		it.seed_a = sa;
		it.seed_b = sb;
		cmd.valid <= 1'b1;
		cmd.opcode <= op;
		cmd.seed_a <= sa;
		cmd.seed_b <= sb;
		do @(posedge clk); while (!cmd.ready);
		pending_responses.push_back(generator_response(it));
		op_count[op]++;
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (pending_responses.size() != 0);
	endtask

	function automatic logic [STATE_W-1:0] pick_seed(input logic [STATE_W-1:0] m);
		case ($urandom_range(3))
			0: return STATE_W'($urandom_range(SEED_MAX, m - 4));
			1: return STATE_W'($urandom_range(15));
			default: return STATE_W'($urandom);
		endcase
	endfunction

	task automatic test_reset_state();
		send_cmd(OP_NEXT, '0, '0);
		send_cmd(OP_NEXT, SEED_MAX, SEED_MAX);
	endtask

	task automatic test_seed_extremes();
		send_cmd(OP_SEED, '0, '0);
		send_cmd(OP_NEXT, '0, '0);
		send_cmd(OP_SEED, SEED_MAX, SEED_MAX);
		send_cmd(OP_NEXT, '0, '0);
		send_cmd(OP_SEED, SEED_ONE, SEED_TWO);
		send_cmd(OP_NEXT, '0, '0);
		send_cmd(OP_SEED, SEED_ONE - 1, SEED_TWO - 1);
		send_cmd(OP_NEXT, '0, '0);
		send_cmd(OP_SEED, 31'h2AAA_AAAA, 31'h5555_5555);
		send_cmd(OP_NEXT, '0, '0);
	endtask

	task automatic test_split_wrap();
		// both states at the wrap points
		send_cmd(OP_SEED, SEED_ONE - 1, '0);
		send_cmd(OP_SPLIT, SEED_MAX, '0);
		send_cmd(OP_NEXT, '0, '0);
		send_cmd(OP_SPLIT, '0, SEED_MAX);
		send_cmd(OP_SEED, 31'd5, SEED_TWO);
		send_cmd(OP_SPLIT, '0, '0);
	endtask

	task automatic test_unused_opcode();
		send_cmd(OP_UNUSED, SEED_MAX, SEED_MAX);
		send_cmd(OP_NEXT, '0, '0);
		send_cmd(OP_UNUSED, '0, '0);
		send_cmd(OP_NEXT, '0, '0);
	endtask

	task automatic test_random_traffic(input int count, input int idle, input int stall);
		int         pick;
		logic [1:0] op;
		idle_pct = idle;
		stall_pct = stall;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				op = OP_SEED;
			end else if (pick < 65) begin
				op = OP_NEXT;
			end else if (pick < 92) begin
				op = OP_SPLIT;
			end else begin
				op = OP_UNUSED;
			end
			send_cmd(op, pick_seed(SEED_ONE), pick_seed(SEED_TWO));
			if (k % 64 == 63) begin
				wait_drained();
			end
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_responses.size() == 0) begin
				$error("response beat with nothing expected");
				error_count++;
			end else begin
				want_rsp = pending_responses.pop_front();
				checked_count++;
				if (rsp.random_value !== want_rsp.random_value) begin
					$error("random_value: expected %0d, got %0d",
						want_rsp.random_value, rsp.random_value);
					error_count++;
				end
				if (rsp.child_first !== want_rsp.child_first) begin
					$error("child_first: expected %0d, got %0d",
						want_rsp.child_first, rsp.child_first);
					error_count++;
				end
				if (rsp.child_second !== want_rsp.child_second) begin
					$error("child_second: expected %0d, got %0d",
						want_rsp.child_second, rsp.child_second);
					error_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.opcode = OP_SEED;
		cmd.seed_a = '0;
		cmd.seed_b = '0;
		rsp.ready = 1'b0;
		lcg_one = STATE_W'(1);
		lcg_two = STATE_W'(1);
		idle_pct = 0;
		stall_pct = 0;
		error_count = 0;
		checked_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_seed_extremes();
		test_split_wrap();
		test_unused_opcode();
		wait_drained();
		test_random_traffic(190, 0, 0);
		test_random_traffic(190, 68, 0);
		test_random_traffic(190, 0, 68);
		test_random_traffic(180, 30, 30);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d seed, %0d draw, %0d split and %0d unused commands",
			op_count[OP_SEED], op_count[OP_NEXT], op_count[OP_SPLIT], op_count[OP_UNUSED]);
		$display("%0d response beats checked under gaps and stalls", checked_count);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
